// ----- sv/ftq_pkg.sv -----
// Shared types for the frame to quaternion pipeline.
`timescale 1ns / 1ps
`default_nettype none

package ftq_pkg;

   typedef enum logic [1:0] {
      BR_TRACE,
      BR_X,
      BR_Y,
      BR_Z
   } branch_type;

   typedef struct packed {
      logic       valid;
      branch_type branch;
   } ctl_type;

endpackage

`default_nettype wire

// ----- sv/ftq_front.sv -----
// Front end: rounded cross products, matrix saturation, branch choice, root argument.
`timescale 1ns / 1ps
`default_nettype none

module ftq_front #(
   parameter int F  = 14,
   parameter int CW = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  enable,
   input  wire logic                  up_valid,
   input  wire logic signed [CW-1:0]  nx,
   input  wire logic signed [CW-1:0]  ny,
   input  wire logic signed [CW-1:0]  nz,
   input  wire logic signed [CW-1:0]  cx,
   input  wire logic signed [CW-1:0]  cy,
   input  wire logic signed [CW-1:0]  cz,
   output ftq_pkg::ctl_type           dn_ctl,
   output logic [F+2:0]               dn_arg,
   output logic signed [F+2:0]        dn_d0,
   output logic signed [F+2:0]        dn_d1,
   output logic signed [F+2:0]        dn_d2
);

   localparam int EW = F + 2;
   localparam int XW = ((CW > EW) ? CW : EW) + 1;
   localparam int PW = 2 * CW + 1;
   localparam int DW = F + 3;
   localparam int AW = F + 3;
   localparam int TW = EW + 2;
   localparam int GW = AW + 2;

   function automatic logic signed [EW-1:0] clamp_in(input logic signed [CW-1:0] v);
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] one;
      x   = XW'(v);
      one = XW'(1) << F;
      if (x > one) begin
         return EW'(one);
      end else if (x < -one) begin
         return EW'(-one);
      end
      return EW'(x);
   endfunction

   function automatic logic signed [EW-1:0] clamp_wide(input logic signed [PW:0] v);
      logic signed [PW:0] one;
      one = (PW+1)'(1) << F;
      if (v > one) begin
         return EW'(one);
      end else if (v < -one) begin
         return EW'(-one);
      end
      return EW'(v);
   endfunction

   function automatic logic signed [PW-1:0] mul_rnd(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
      logic signed [2*CW-1:0] p;
      logic signed [PW-1:0]   t;
      p = a * b;
      t = PW'(p) + (PW'(1) << (F - 1));
      return t >>> F;
   endfunction

   logic                 v1_ff, v1_in;
   logic signed [EW-1:0] r00_ff, r10_ff, r20_ff, r01_ff, r11_ff, r21_ff;
   logic signed [PW-1:0] p_ny_cz_ff, p_nz_cy_ff, p_nz_cx_ff;
   logic signed [PW-1:0] p_nx_cz_ff, p_nx_cy_ff, p_ny_cx_ff;

   assign v1_in = up_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         r00_ff     <= clamp_in(nx);
         r10_ff     <= clamp_in(ny);
         r20_ff     <= clamp_in(nz);
         r01_ff     <= clamp_in(cx);
         r11_ff     <= clamp_in(cy);
         r21_ff     <= clamp_in(cz);
         p_ny_cz_ff <= mul_rnd(ny, cz);
         p_nz_cy_ff <= mul_rnd(nz, cy);
         p_nz_cx_ff <= mul_rnd(nz, cx);
         p_nx_cz_ff <= mul_rnd(nx, cz);
         p_nx_cy_ff <= mul_rnd(nx, cy);
         p_ny_cx_ff <= mul_rnd(ny, cx);
      end
   end

   logic signed [EW-1:0] r02, r12, r22;
   logic signed [TW-1:0] tr;
   logic signed [GW-1:0] arg_s, one_g;
   ftq_pkg::ctl_type     ctl_ff, ctl_in;
   logic [AW-1:0]        arg_ff, arg_in;
   logic signed [DW-1:0] d0_ff, d0_in, d1_ff, d1_in, d2_ff, d2_in;

   always_comb begin
      r02   = clamp_wide((PW+1)'(p_ny_cz_ff) - (PW+1)'(p_nz_cy_ff));
      r12   = clamp_wide((PW+1)'(p_nz_cx_ff) - (PW+1)'(p_nx_cz_ff));
      r22   = clamp_wide((PW+1)'(p_nx_cy_ff) - (PW+1)'(p_ny_cx_ff));
      tr    = TW'(r00_ff) + TW'(r11_ff) + TW'(r22);
      one_g = GW'(1) << F;
      ctl_in.valid = v1_ff;
      if (tr > 0) begin
         ctl_in.branch = ftq_pkg::BR_TRACE;
         arg_s = one_g + GW'(tr);
         d0_in = DW'(r21_ff) - DW'(r12);
         d1_in = DW'(r02) - DW'(r20_ff);
         d2_in = DW'(r10_ff) - DW'(r01_ff);
      end else if (r00_ff > r11_ff && r00_ff > r22) begin
         ctl_in.branch = ftq_pkg::BR_X;
         arg_s = one_g + GW'(r00_ff) - GW'(r11_ff) - GW'(r22);
         d0_in = DW'(r21_ff) - DW'(r12);
         d1_in = DW'(r01_ff) + DW'(r10_ff);
         d2_in = DW'(r02) + DW'(r20_ff);
      end else if (r11_ff > r22) begin
         ctl_in.branch = ftq_pkg::BR_Y;
         arg_s = one_g + GW'(r11_ff) - GW'(r00_ff) - GW'(r22);
         d0_in = DW'(r02) - DW'(r20_ff);
         d1_in = DW'(r01_ff) + DW'(r10_ff);
         d2_in = DW'(r12) + DW'(r21_ff);
      end else begin
         ctl_in.branch = ftq_pkg::BR_Z;
         arg_s = one_g + GW'(r22) - GW'(r00_ff) - GW'(r11_ff);
         d0_in = DW'(r10_ff) - DW'(r01_ff);
         d1_in = DW'(r02) + DW'(r20_ff);
         d2_in = DW'(r12) + DW'(r21_ff);
      end
      arg_in = (arg_s < 0) ? '0 : AW'(arg_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         arg_ff        <= arg_in;
         d0_ff         <= d0_in;
         d1_ff         <= d1_in;
         d2_ff         <= d2_in;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_arg = arg_ff;
   assign dn_d0  = d0_ff;
   assign dn_d1  = d1_ff;
   assign dn_d2  = d2_ff;

endmodule

`default_nettype wire

// ----- sv/ftq_sqrt_cell.sv -----
// One digit cell of the pipelined integer square root.
`timescale 1ns / 1ps
`default_nettype none

module ftq_sqrt_cell #(
   parameter int RMW = 18,
   parameter int RB  = 16,
   parameter int SW  = 32,
   parameter int PW  = 8
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           enable,
   input  wire logic           up_valid,
   input  wire logic [RMW-1:0] up_rem,
   input  wire logic [RB-1:0]  up_root,
   input  wire logic [SW-1:0]  up_rad,
   input  wire logic [PW-1:0]  up_pass,
   output logic                dn_valid,
   output logic [RMW-1:0]      dn_rem,
   output logic [RB-1:0]       dn_root,
   output logic [SW-1:0]       dn_rad,
   output logic [PW-1:0]       dn_pass
);

   logic           valid_ff;
   logic [RMW-1:0] rem_ff, rem_in;
   logic [RB-1:0]  root_ff, root_in;
   logic [SW-1:0]  rad_ff, rad_in;
   logic [PW-1:0]  pass_ff;
   logic [RMW+1:0] cur, trial;

   always_comb begin
      cur    = {up_rem, up_rad[SW-1:SW-2]};
      trial  = (RMW+2)'({up_root, 2'b01});
      rad_in = up_rad << 2;
      if (cur >= trial) begin
         rem_in  = RMW'(cur - trial);
         root_in = {up_root[RB-2:0], 1'b1};
      end else begin
         rem_in  = RMW'(cur);
         root_in = {up_root[RB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
         pass_ff <= up_pass;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_rad   = rad_ff;
   assign dn_pass  = pass_ff;

endmodule

`default_nettype wire

// ----- sv/ftq_div_cell.sv -----
// One quotient-bit cell of the pipelined restoring divider.
`timescale 1ns / 1ps
`default_nettype none

module ftq_div_cell #(
   parameter int NW  = 33,
   parameter int SBW = 17,
   parameter int QB  = 16,
   parameter int K   = 0,
   parameter int PW  = 2
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           enable,
   input  wire logic           up_valid,
   input  wire logic [NW-1:0]  up_rem,
   input  wire logic [SBW-1:0] up_div,
   input  wire logic [QB-1:0]  up_quo,
   input  wire logic [PW-1:0]  up_pass,
   output logic                dn_valid,
   output logic [NW-1:0]       dn_rem,
   output logic [SBW-1:0]      dn_div,
   output logic [QB-1:0]       dn_quo,
   output logic [PW-1:0]       dn_pass
);

   logic           valid_ff;
   logic [NW-1:0]  rem_ff, rem_in, shifted;
   logic [SBW-1:0] div_ff;
   logic [QB-1:0]  quo_ff, quo_in;
   logic [PW-1:0]  pass_ff;

   always_comb begin
      shifted = NW'(up_div) << K;
      if (up_rem >= shifted) begin
         rem_in = up_rem - shifted;
         quo_in = up_quo | (QB'(1) << K);
      end else begin
         rem_in = up_rem;
         quo_in = up_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         div_ff  <= up_div;
         quo_ff  <= quo_in;
         pass_ff <= up_pass;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_div   = div_ff;
   assign dn_quo   = quo_ff;
   assign dn_pass  = pass_ff;

endmodule

`default_nettype wire

// ----- sv/frame_to_quaternion.sv -----
// Top level: local frame (normal, curvature) to unit quaternion pipeline.
//
// Input channel req_*: one transaction per point, normal and curvature vectors,
// signed fixed point with FRAC_BITS fraction bits. Output channel rsp_*: one
// transaction per input, quaternion (w,x,y,z) saturated to +/-1.0, plus the
// degenerate flag (zero divisor, quaternion forced to zero).
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low.
// Throughput: one transaction per cycle unless the receiver stalls. Stages: two
// front stages, FRAC_BITS+2 square-root cells, one divisor setup stage,
// FRAC_BITS+2 divider cells per lane (three lanes) and the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// req_stall is raised; otherwise a new input is taken every cycle.
// Reset (synchronous) clears all valid bits; no results are in flight after it.
`timescale 1ns / 1ps
`default_nettype none

module frame_to_quaternion #(
   parameter int FRAC_BITS  = 14,
   parameter int COMP_WIDTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COMP_WIDTH-1:0] req_normal_x,
   input  wire logic signed [COMP_WIDTH-1:0] req_normal_y,
   input  wire logic signed [COMP_WIDTH-1:0] req_normal_z,
   input  wire logic signed [COMP_WIDTH-1:0] req_curv_x,
   input  wire logic signed [COMP_WIDTH-1:0] req_curv_y,
   input  wire logic signed [COMP_WIDTH-1:0] req_curv_z,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [COMP_WIDTH-1:0]      rsp_quat_w,
   output logic signed [COMP_WIDTH-1:0]      rsp_quat_x,
   output logic signed [COMP_WIDTH-1:0]      rsp_quat_y,
   output logic signed [COMP_WIDTH-1:0]      rsp_quat_z,
   output logic                              rsp_degenerate
);

   localparam int F   = FRAC_BITS;
   localparam int CW  = COMP_WIDTH;
   localparam int DW  = F + 3;
   localparam int AW  = F + 3;
   localparam int RB  = F + 2;
   localparam int RMW = F + 4;
   localparam int SW  = 2 * F + 4;
   localparam int CTW = $bits(ftq_pkg::ctl_type);
   localparam int SPW = CTW + 3 * DW;
   localparam int SBW = F + 3;
   localparam int QB  = F + 2;
   localparam int NW  = 2 * F + 5;
   localparam int BW  = F + 1;
   localparam int P0W = CTW + BW + 3;
   localparam int LW  = ((F + 3 > CW) ? F + 3 : CW) + 1;

   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   ftq_pkg::ctl_type     fr_ctl;
   logic [AW-1:0]        fr_arg;
   logic signed [DW-1:0] fr_d0, fr_d1, fr_d2;

   ftq_front #(.F(F), .CW(CW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (adv),
      .up_valid (req_valid),
      .nx       (req_normal_x),
      .ny       (req_normal_y),
      .nz       (req_normal_z),
      .cx       (req_curv_x),
      .cy       (req_curv_y),
      .cz       (req_curv_z),
      .dn_ctl   (fr_ctl),
      .dn_arg   (fr_arg),
      .dn_d0    (fr_d0),
      .dn_d1    (fr_d1),
      .dn_d2    (fr_d2)
   );

   logic           sq_valid [0:RB];
   logic [RMW-1:0] sq_rem   [0:RB];
   logic [RB-1:0]  sq_root  [0:RB];
   logic [SW-1:0]  sq_rad   [0:RB];
   logic [SPW-1:0] sq_pass  [0:RB];

   assign sq_valid[0] = fr_ctl.valid;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_rad[0]   = SW'({fr_arg, {F{1'b0}}});
   assign sq_pass[0]  = {fr_ctl, fr_d0, fr_d1, fr_d2};

   for (genvar i = 0; i < RB; i++) begin : g_sqrt
      ftq_sqrt_cell #(.RMW(RMW), .RB(RB), .SW(SW), .PW(SPW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (adv),
         .up_valid (sq_valid[i]),
         .up_rem   (sq_rem[i]),
         .up_root  (sq_root[i]),
         .up_rad   (sq_rad[i]),
         .up_pass  (sq_pass[i]),
         .dn_valid (sq_valid[i+1]),
         .dn_rem   (sq_rem[i+1]),
         .dn_root  (sq_root[i+1]),
         .dn_rad   (sq_rad[i+1]),
         .dn_pass  (sq_pass[i+1])
      );
   end

   // divisor setup
   ftq_pkg::ctl_type     sq_ctl;
   logic signed [DW-1:0] sq_d [0:2];
   logic [RB-1:0]        root;
   logic [SBW-1:0]       s_in;
   logic [BW-1:0]        big_in;
   logic [NW-1:0]        num_in [0:2];
   logic                 neg_in [0:2];
   logic                 ovf_in [0:2];
   logic [DW-1:0]        mag;

   always_comb begin
      {sq_ctl, sq_d[0], sq_d[1], sq_d[2]} = sq_pass[RB];
      root   = sq_root[RB];
      s_in   = {root, 1'b0};
      big_in = BW'((SBW'(root) + SBW'(1)) >> 1);
      for (int l = 0; l < 3; l++) begin
         neg_in[l] = sq_d[l][DW-1];
         mag       = neg_in[l] ? DW'(-sq_d[l]) : DW'(sq_d[l]);
         num_in[l] = (NW'(mag) << F) + NW'(root);
         ovf_in[l] = num_in[l] >= (NW'(s_in) << QB);
      end
   end

   logic                 st_valid_ff;
   ftq_pkg::ctl_type     st_ctl_ff;
   logic [SBW-1:0]       st_s_ff;
   logic [BW-1:0]        st_big_ff;
   logic                 st_deg_ff;
   logic [NW-1:0]        st_num_ff [0:2];
   logic                 st_neg_ff [0:2];
   logic                 st_ovf_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else if (adv) begin
         st_valid_ff <= sq_valid[RB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ctl_ff <= sq_ctl;
         st_s_ff   <= s_in;
         st_big_ff <= big_in;
         st_deg_ff <= (root == '0);
         for (int l = 0; l < 3; l++) begin
            st_num_ff[l] <= num_in[l];
            st_neg_ff[l] <= neg_in[l];
            st_ovf_ff[l] <= ovf_in[l];
         end
      end
   end

   // divider lanes; lane 0 carries the shared item data
   logic           dv_valid [0:2][0:QB];
   logic [NW-1:0]  dv_rem   [0:2][0:QB];
   logic [SBW-1:0] dv_div   [0:2][0:QB];
   logic [QB-1:0]  dv_quo   [0:2][0:QB];
   logic [P0W-1:0] dv_pass0 [0:QB];
   logic [1:0]     dv_pass1 [0:QB];
   logic [1:0]     dv_pass2 [0:QB];

   for (genvar l = 0; l < 3; l++) begin : g_lane_head
      assign dv_valid[l][0] = st_valid_ff;
      assign dv_rem[l][0]   = st_num_ff[l];
      assign dv_div[l][0]   = st_s_ff;
      assign dv_quo[l][0]   = '0;
   end
   assign dv_pass0[0] = {st_ctl_ff, st_big_ff, st_deg_ff, st_neg_ff[0], st_ovf_ff[0]};
   assign dv_pass1[0] = {st_neg_ff[1], st_ovf_ff[1]};
   assign dv_pass2[0] = {st_neg_ff[2], st_ovf_ff[2]};

   for (genvar j = 0; j < QB; j++) begin : g_div
      ftq_div_cell #(.NW(NW), .SBW(SBW), .QB(QB), .K(QB-1-j), .PW(P0W)) u_lane0 (
         .clock (clock), .reset (reset), .enable (adv),
         .up_valid (dv_valid[0][j]), .up_rem (dv_rem[0][j]), .up_div (dv_div[0][j]),
         .up_quo (dv_quo[0][j]), .up_pass (dv_pass0[j]),
         .dn_valid (dv_valid[0][j+1]), .dn_rem (dv_rem[0][j+1]), .dn_div (dv_div[0][j+1]),
         .dn_quo (dv_quo[0][j+1]), .dn_pass (dv_pass0[j+1])
      );
      ftq_div_cell #(.NW(NW), .SBW(SBW), .QB(QB), .K(QB-1-j), .PW(2)) u_lane1 (
         .clock (clock), .reset (reset), .enable (adv),
         .up_valid (dv_valid[1][j]), .up_rem (dv_rem[1][j]), .up_div (dv_div[1][j]),
         .up_quo (dv_quo[1][j]), .up_pass (dv_pass1[j]),
         .dn_valid (dv_valid[1][j+1]), .dn_rem (dv_rem[1][j+1]), .dn_div (dv_div[1][j+1]),
         .dn_quo (dv_quo[1][j+1]), .dn_pass (dv_pass1[j+1])
      );
      ftq_div_cell #(.NW(NW), .SBW(SBW), .QB(QB), .K(QB-1-j), .PW(2)) u_lane2 (
         .clock (clock), .reset (reset), .enable (adv),
         .up_valid (dv_valid[2][j]), .up_rem (dv_rem[2][j]), .up_div (dv_div[2][j]),
         .up_quo (dv_quo[2][j]), .up_pass (dv_pass2[j]),
         .dn_valid (dv_valid[2][j+1]), .dn_rem (dv_rem[2][j+1]), .dn_div (dv_div[2][j+1]),
         .dn_quo (dv_quo[2][j+1]), .dn_pass (dv_pass2[j+1])
      );
   end

   function automatic logic signed [CW-1:0] sat_out(input logic neg, input logic ovf,
                                                     input logic [QB-1:0] q);
      logic signed [LW-1:0] one, v, hi, lo;
      one = LW'(1) << F;
      hi  = (LW'(1) << (CW - 1)) - LW'(1);
      lo  = -(LW'(1) << (CW - 1));
      v   = LW'(q);
      if (ovf || v > one) begin
         v = one;
      end
      if (neg) begin
         v = -v;
      end
      if (v > hi) begin
         v = hi;
      end else if (v < lo) begin
         v = lo;
      end
      return CW'(v);
   endfunction

   ftq_pkg::ctl_type       ot_ctl;
   logic [BW-1:0]          ot_big;
   logic                   ot_deg, ot_neg0, ot_ovf0;
   logic signed [CW-1:0]   qa, qb, qc, qbig;
   logic signed [CW-1:0]   qw_in, qx_in, qy_in, qz_in;
   logic signed [CW-1:0]   qw_ff, qx_ff, qy_ff, qz_ff;
   logic                   deg_ff;

   always_comb begin
      {ot_ctl, ot_big, ot_deg, ot_neg0, ot_ovf0} = dv_pass0[QB];
      qa   = sat_out(ot_neg0, ot_ovf0, dv_quo[0][QB]);
      qb   = sat_out(dv_pass1[QB][1], dv_pass1[QB][0], dv_quo[1][QB]);
      qc   = sat_out(dv_pass2[QB][1], dv_pass2[QB][0], dv_quo[2][QB]);
      qbig = sat_out(1'b0, 1'b0, QB'(ot_big));
      case (ot_ctl.branch)
         ftq_pkg::BR_TRACE: begin
            qw_in = qbig; qx_in = qa; qy_in = qb; qz_in = qc;
         end
         ftq_pkg::BR_X: begin
            qw_in = qa; qx_in = qbig; qy_in = qb; qz_in = qc;
         end
         ftq_pkg::BR_Y: begin
            qw_in = qa; qx_in = qb; qy_in = qbig; qz_in = qc;
         end
         default: begin
            qw_in = qa; qx_in = qb; qy_in = qc; qz_in = qbig;
         end
      endcase
      if (ot_deg) begin
         qw_in = '0; qx_in = '0; qy_in = '0; qz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid[0][QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qw_ff  <= qw_in;
         qx_ff  <= qx_in;
         qy_ff  <= qy_in;
         qz_ff  <= qz_in;
         deg_ff <= ot_deg;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_quat_w     = qw_ff;
   assign rsp_quat_x     = qx_ff;
   assign rsp_quat_y     = qy_ff;
   assign rsp_quat_z     = qz_ff;
   assign rsp_degenerate = deg_ff;

endmodule

`default_nettype wire

// ----- sv/ftq_checker.sv -----
// Port-level checks for the frame to quaternion block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ftq_checker #(
   parameter int FRAC_BITS  = 14,
   parameter int COMP_WIDTH = 16
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic signed [COMP_WIDTH-1:0] req_normal_x,
   input wire logic signed [COMP_WIDTH-1:0] req_normal_y,
   input wire logic signed [COMP_WIDTH-1:0] req_normal_z,
   input wire logic signed [COMP_WIDTH-1:0] req_curv_x,
   input wire logic signed [COMP_WIDTH-1:0] req_curv_y,
   input wire logic signed [COMP_WIDTH-1:0] req_curv_z,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic signed [COMP_WIDTH-1:0] rsp_quat_w,
   input wire logic signed [COMP_WIDTH-1:0] rsp_quat_x,
   input wire logic signed [COMP_WIDTH-1:0] rsp_quat_y,
   input wire logic signed [COMP_WIDTH-1:0] rsp_quat_z,
   input wire logic                         rsp_degenerate
);

   localparam int CW = COMP_WIDTH;
   localparam int LW = ((FRAC_BITS + 2 > CW) ? FRAC_BITS + 2 : CW) + 1;
   localparam logic signed [LW-1:0] ONE = LW'(1) << FRAC_BITS;

   logic unused_req;
   assign unused_req = ^{req_valid, req_normal_x, req_normal_y, req_normal_z,
                         req_curv_x, req_curv_y, req_curv_z};

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quat_w) && $stable(rsp_quat_x)
         && $stable(rsp_quat_y) && $stable(rsp_quat_z) && $stable(rsp_degenerate))
      else $error("stalled result changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output stall");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_quat_w == 0 && rsp_quat_x == 0
         && rsp_quat_y == 0 && rsp_quat_z == 0)
      else $error("degenerate result not zero");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> LW'(rsp_quat_w) <= ONE && LW'(rsp_quat_w) >= -ONE
         && LW'(rsp_quat_x) <= ONE && LW'(rsp_quat_x) >= -ONE
         && LW'(rsp_quat_y) <= ONE && LW'(rsp_quat_y) >= -ONE
         && LW'(rsp_quat_z) <= ONE && LW'(rsp_quat_z) >= -ONE)
      else $error("quaternion component beyond one");

endmodule

bind frame_to_quaternion ftq_checker #(
   .FRAC_BITS  (FRAC_BITS),
   .COMP_WIDTH (COMP_WIDTH)
) u_ftq_checker (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the frame to quaternion pipeline.
`timescale 1ns / 1ps

module testbench;

   localparam int FRAC = 14;
   localparam int CW = 16;
   localparam int LATENCY = 2 * FRAC + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam longint ONE = 64'sd1 <<< FRAC;

   typedef struct {
      logic signed [CW-1:0] nx, ny, nz, cx, cy, cz;
   } frame_type;

   typedef struct {
      logic signed [CW-1:0] w, x, y, z;
      logic                 degenerate;
   } quat_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [CW-1:0] req_normal_x = 0, req_normal_y = 0, req_normal_z = 0;
   logic signed [CW-1:0] req_curv_x = 0, req_curv_y = 0, req_curv_z = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [CW-1:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   logic rsp_degenerate;

   frame_type frame_queue[$];
   quat_type  quat_expected[$];
   int     send_idle_pct = 0;
   int     recv_idle_pct = 0;
   int     mismatches = 0;
   int     idle_cycles = 0;
   bit     timed_out = 0;

   frame_to_quaternion u_dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint prod_rounded(longint a, longint b);
      return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint div_nearest(longint d, longint s);
      longint mag;
      longint q;
      mag = (d < 0 ? -d : d) <<< FRAC;
      q = (mag + s / 2) / s;
      return d < 0 ? -q : q;
   endfunction

   function automatic longint int_sqrt(longint a);
      longint r;
      r = 0;
      for (longint b = 64'sd1 <<< 24; b > 0; b = b >>> 1) begin
         if ((r + b) * (r + b) <= a) r = r + b;
      end
      return r;
   endfunction

   function automatic quat_type frame_quaternion(frame_type f);
      quat_type res;
      longint  r00, r10, r20, r01, r11, r21, r02, r12, r22, tr, arg, root, s, big;
      longint  q[4];
      ftq_pkg::branch_type br;
      r00 = sat(f.nx, -ONE, ONE);
      r10 = sat(f.ny, -ONE, ONE);
      r20 = sat(f.nz, -ONE, ONE);
      r01 = sat(f.cx, -ONE, ONE);
      r11 = sat(f.cy, -ONE, ONE);
      r21 = sat(f.cz, -ONE, ONE);
      r02 = sat(prod_rounded(f.ny, f.cz) - prod_rounded(f.nz, f.cy), -ONE, ONE);
      r12 = sat(prod_rounded(f.nz, f.cx) - prod_rounded(f.nx, f.cz), -ONE, ONE);
      r22 = sat(prod_rounded(f.nx, f.cy) - prod_rounded(f.ny, f.cx), -ONE, ONE);
      tr = r00 + r11 + r22;
      if (tr > 0) begin
         br = ftq_pkg::BR_TRACE;
         arg = ONE + tr;
      end else if (r00 > r11 && r00 > r22) begin
         br = ftq_pkg::BR_X;
         arg = ONE + r00 - r11 - r22;
      end else if (r11 > r22) begin
         br = ftq_pkg::BR_Y;
         arg = ONE + r11 - r00 - r22;
      end else begin
         br = ftq_pkg::BR_Z;
         arg = ONE + r22 - r00 - r11;
      end
      if (arg < 0) arg = 0;
      root = int_sqrt(arg <<< FRAC);
      s = 2 * root;
      res.degenerate = (s == 0);
      if (s == 0) begin
         res.w = 0; res.x = 0; res.y = 0; res.z = 0;
         return res;
      end
      big = (root + 1) >>> 1;
      case (br)
         ftq_pkg::BR_TRACE: begin
            q[0] = big;
            q[1] = div_nearest(r21 - r12, s);
            q[2] = div_nearest(r02 - r20, s);
            q[3] = div_nearest(r10 - r01, s);
         end
         ftq_pkg::BR_X: begin
            q[0] = div_nearest(r21 - r12, s);
            q[1] = big;
            q[2] = div_nearest(r01 + r10, s);
            q[3] = div_nearest(r02 + r20, s);
         end
         ftq_pkg::BR_Y: begin
            q[0] = div_nearest(r02 - r20, s);
            q[1] = div_nearest(r01 + r10, s);
            q[2] = big;
            q[3] = div_nearest(r12 + r21, s);
         end
         default: begin
            q[0] = div_nearest(r10 - r01, s);
            q[1] = div_nearest(r02 + r20, s);
            q[2] = div_nearest(r12 + r21, s);
            q[3] = big;
         end
      endcase
      res.w = sat(q[0], -ONE, ONE);
      res.x = sat(q[1], -ONE, ONE);
      res.y = sat(q[2], -ONE, ONE);
      res.z = sat(q[3], -ONE, ONE);
      return res;
   endfunction

   function automatic logic signed [CW-1:0] rand_comp();
      case ($urandom_range(0, 9))
         0: return CW'($urandom);
         1: return CW'($urandom_range(0, 4) == 0 ? -ONE : ONE);
         2: return 0;
         default: return CW'(int'($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic frame_type make_frame(int a, int b, int c, int d, int e, int g);
      frame_type f;
      f.nx = CW'(a); f.ny = CW'(b); f.nz = CW'(c);
      f.cx = CW'(d); f.cy = CW'(e); f.cz = CW'(g);
      return f;
   endfunction

   function automatic frame_type rand_unit_frame();
      frame_type f;
      real    ax, ay, az, bx, by, bz, len, dt;
      ax = $urandom_range(0, 2000) - 1000.0;
      ay = $urandom_range(0, 2000) - 1000.0;
      az = $urandom_range(0, 2000) - 1000.0;
      len = $sqrt(ax * ax + ay * ay + az * az) + 1.0e-9;
      ax = ax / len; ay = ay / len; az = az / len;
      bx = $urandom_range(0, 2000) - 1000.0;
      by = $urandom_range(0, 2000) - 1000.0;
      bz = $urandom_range(0, 2000) - 1000.0;
      dt = ax * bx + ay * by + az * bz;
      bx = bx - dt * ax; by = by - dt * ay; bz = bz - dt * az;
      len = $sqrt(bx * bx + by * by + bz * bz) + 1.0e-9;
      f.nx = CW'($rtoi(ax * ONE)); f.ny = CW'($rtoi(ay * ONE));
      f.nz = CW'($rtoi(az * ONE));
      f.cx = CW'($rtoi(bx / len * ONE)); f.cy = CW'($rtoi(by / len * ONE));
      f.cz = CW'($rtoi(bz / len * ONE));
      return f;
   endfunction

   initial begin
      frame_type f;
      frame_queue.push_back(make_frame(16384, 0, 0, 0, 16384, 0));
      frame_queue.push_back(make_frame(16384, 0, 0, 0, -16384, 0));
      frame_queue.push_back(make_frame(-16384, 0, 0, 0, 16384, 0));
      frame_queue.push_back(make_frame(-16384, 0, 0, 0, -16384, 0));
      frame_queue.push_back(make_frame(0, 0, 0, 0, 0, 0));
      frame_queue.push_back(make_frame(0, 16384, 0, 16384, 0, 0));
      frame_queue.push_back(make_frame(0, 0, 16384, 0, 16384, 0));
      frame_queue.push_back(make_frame(0, 0, -16384, 0, 0, 16384));
      frame_queue.push_back(make_frame(-16384, -16384, -16384, -16384, -16384, -16384));
      frame_queue.push_back(make_frame(16384, 16384, 16384, 16384, 16384, 16384));
      frame_queue.push_back(make_frame(32767, 32767, 32767, -32768, -32768, -32768));
      frame_queue.push_back(make_frame(-32768, 32767, -32768, 32767, -32768, 32767));
      frame_queue.push_back(make_frame(-1, -1, -1, -1, -1, -1));
      frame_queue.push_back(make_frame(16384, 0, 0, 0, 0, 0));
      frame_queue.push_back(make_frame(-16384, 0, 0, 0, 0, 0));
      frame_queue.push_back(make_frame(0, 0, 0, 0, -16384, 0));
      frame_queue.push_back(make_frame(0, 16384, 0, 0, 0, 16384));
      frame_queue.push_back(make_frame(11585, 11585, 0, -11585, 11585, 0));
      frame_queue.push_back(make_frame(-8192, 8192, -8192, 8192, 8192, 0));
      frame_queue.push_back(make_frame(1, 2, 3, 4, 5, 6));
      for (int i = 0; i < 630; i++) begin
         if ($urandom_range(0, 9) < 6) f = rand_unit_frame();
         else begin
            f.nx = rand_comp(); f.ny = rand_comp(); f.nz = rand_comp();
            f.cx = rand_comp(); f.cy = rand_comp(); f.cz = rand_comp();
         end
         frame_queue.push_back(f);
      end
   end

   // driver
   always @(posedge clock) begin
      frame_type f;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || !req_stall) begin
         if (frame_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            f = frame_queue.pop_front();
            req_valid <= 1;
            req_normal_x <= f.nx; req_normal_y <= f.ny; req_normal_z <= f.nz;
            req_curv_x <= f.cx; req_curv_y <= f.cy; req_curv_z <= f.cz;
            quat_expected.push_back(frame_quaternion(f));
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      quat_type e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (quat_expected.size() <= 1 && !(req_valid && !req_stall)
                  && quat_expected.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected transaction");
            end else begin
               e = quat_expected.pop_front();
               if (e.w !== rsp_quat_w || e.x !== rsp_quat_x || e.y !== rsp_quat_y
                     || e.z !== rsp_quat_z || e.degenerate !== rsp_degenerate) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("exp %0d %0d %0d %0d d%0b got %0d %0d %0d %0d d%0b",
                        e.w, e.x, e.y, e.z, e.degenerate, rsp_quat_w, rsp_quat_x,
                        rsp_quat_y, rsp_quat_z, rsp_degenerate);
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      send_idle_pct = 30;
      recv_idle_pct = 56;
      wait (frame_queue.size() < 434);
      send_idle_pct = 56;
      recv_idle_pct = 30;
      wait (frame_queue.size() < 217);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait ((frame_queue.size() == 0 && quat_expected.size() == 0) || timed_out);
      if (!timed_out) repeat (LATENCY + 4) @(posedge clock);
      if (!timed_out && mismatches == 0 && quat_expected.size() == 0)
         $display("frame_to_quaternion: match");
      else
         $display("frame_to_quaternion: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1;
   end

endmodule
